### sv/pcsp_pkg.sv
package pcsp_pkg;

  typedef struct packed {
    logic [7:0]         character;
    logic signed [31:0] star_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  padding_mode;
    logic [1:0]  sign_mode;
    logic        precision_given;
    logic        alternate_form;
    logic [3:0]  length_kind;
    logic [7:0]  conversion_code;
    logic [31:0] field_width;
    logic [31:0] precision_value;
    logic        terminator_taken;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_FIRST  = 4'd0,
    PH_FLAGS  = 4'd1,
    PH_WDIG   = 4'd2,
    PH_AFTERW = 4'd3,
    PH_SKIP   = 4'd4,
    PH_PSTART = 4'd5,
    PH_PDIG   = 4'd6,
    PH_LEN    = 4'd7,
    PH_AFTERH = 4'd8,
    PH_AFTERL = 4'd9,
    PH_CONV   = 4'd10
  } phase_t;

  localparam logic [1:0] PAD_RIGHT = 2'd0;
  localparam logic [1:0] PAD_LEFT  = 2'd1;
  localparam logic [1:0] PAD_ZERO  = 2'd2;

  localparam logic [1:0] SGN_NONE  = 2'd0;
  localparam logic [1:0] SGN_PLUS  = 2'd1;
  localparam logic [1:0] SGN_SPACE = 2'd2;

  localparam logic [3:0] LK_NONE = 4'd0;
  localparam logic [3:0] LK_HH   = 4'd1;
  localparam logic [3:0] LK_H    = 4'd2;
  localparam logic [3:0] LK_L    = 4'd3;
  localparam logic [3:0] LK_LL   = 4'd4;
  localparam logic [3:0] LK_J    = 4'd5;
  localparam logic [3:0] LK_Z    = 4'd6;
  localparam logic [3:0] LK_T    = 4'd7;
  localparam logic [3:0] LK_BIGL = 4'd8;
  localparam logic [3:0] LK_WIDE = 4'd9;

  localparam logic [7:0] CODE_BAD = 8'hFF;
  localparam logic [31:0] MAX_FIELD_RESET = 32'd4095;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

endpackage

### sv/printf_conversion_spec_parser_top.sv
// Parser for the conversion specification of a printf format string.
// The input channel carries the bytes that follow a percent sign, one item
// per byte, with the integer argument that is used when the byte is an asterisk.
// The output channel carries one descriptor item when a conversion ends:
// padding, sign, alternate form, length kind, conversion code, width and
// precision. Bytes inside a specification produce no output item.
// The configuration channel writes max_field, the largest allowed width, and
// is always ready. The user must write it only while the parser is idle; the
// block itself does not enforce this. An accepted item is held in an input
// register until the output register can take a result; its descriptor, if
// any, is then loaded into the output register, which drives out_valid.
// Throughput is one item per cycle while the receiver does not stall, set by
// the update of the parse phase and the working fields between the two registers.
// When the receiver stalls, the output register holds its item and the input
// register fills; in_ready then falls until out_ready returns.
// Reset sets max_field to 4095, empties both registers and puts the parser
// at the first byte after a percent sign.
module printf_conversion_spec_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcsp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import pcsp_pkg::*;

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        s1_go;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [31:0] max_field_r;
  logic        res_valid;
  out_item_t   res;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  pcsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .item      (s1_item_r),
    .max_field (max_field_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_field_r <= MAX_FIELD_RESET;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        max_field_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_go && res_valid) begin
      out_item_r <= res;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_go)
    else $error("pending output item overwritten");

  a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without cause");

  a_output_from_parser: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && res_valid))
    else $error("output item appeared without a parser result");
`endif

endmodule

### sv/pcsp_core.sv
module pcsp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  pcsp_pkg::in_item_t item,
  input  logic [31:0]        max_field,
  output logic               res_valid,
  output pcsp_pkg::out_item_t res
);
  import pcsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [1:0]  sgn_r, sgn_nxt;
  logic        pgiven_r, pgiven_nxt;
  logic        alt_r, alt_nxt;
  logic [3:0]  lkind_r, lkind_nxt;
  logic [31:0] fwidth_r, fwidth_nxt;
  logic [31:0] prec_r, prec_nxt;

  logic [7:0]  c;
  logic [31:0] star;
  logic [31:0] star_mag;
  logic        is_dig;
  logic [31:0] acc;
  logic [35:0] acc_sum;
  logic [31:0] acc_next;
  logic        emit;
  logic [7:0]  code;
  logic        taken;
  logic        go_endw, go_afterw, go_len, go_conv, go_inval;

  assign c        = item.character;
  assign star     = item.star_value;
  assign star_mag = star[31] ? (~star + 32'd1) : star;
  assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign acc      = (phase_r == PH_PDIG) ? prec_r : fwidth_r;
  assign acc_sum  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, c[3:0]};
  assign acc_next = (acc_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];

  always_comb begin
    phase_nxt  = phase_r;
    pad_nxt    = pad_r;
    sgn_nxt    = sgn_r;
    pgiven_nxt = pgiven_r;
    alt_nxt    = alt_r;
    lkind_nxt  = lkind_r;
    fwidth_nxt = fwidth_r;
    prec_nxt   = prec_r;
    emit       = 1'b0;
    code       = c;
    taken      = (c != CH_NUL);
    go_endw    = 1'b0;
    go_afterw  = 1'b0;
    go_len     = 1'b0;
    go_conv    = 1'b0;
    go_inval   = 1'b0;
    res        = '0;

    if ((phase_r == PH_FIRST) || (phase_r > PH_CONV)) begin
      pad_nxt    = PAD_RIGHT;
      sgn_nxt    = SGN_NONE;
      pgiven_nxt = 1'b0;
      alt_nxt    = 1'b0;
      lkind_nxt  = LK_NONE;
      fwidth_nxt = '0;
      prec_nxt   = '0;
    end

    case (phase_r)
      PH_WDIG: begin
        if (is_dig) begin
          fwidth_nxt = acc_next;
        end else begin
          go_endw = 1'b1;
        end
      end
      PH_AFTERW: go_afterw = 1'b1;
      PH_SKIP:   go_inval = 1'b1;
      PH_PSTART: begin
        if (c == CH_STAR) begin
          if (star[31]) begin
            pgiven_nxt = 1'b0;
          end else begin
            prec_nxt = star;
          end
          phase_nxt = PH_LEN;
        end else if (is_dig) begin
          prec_nxt  = {28'd0, c[3:0]};
          phase_nxt = PH_PDIG;
        end else begin
          prec_nxt = '0;
          go_len   = 1'b1;
        end
      end
      PH_PDIG: begin
        if (is_dig) begin
          prec_nxt = acc_next;
        end else begin
          go_len = 1'b1;
        end
      end
      PH_LEN: go_len = 1'b1;
      PH_AFTERH: begin
        if (c == "h") begin
          lkind_nxt = LK_HH;
          phase_nxt = PH_CONV;
        end else begin
          go_conv = 1'b1;
        end
      end
      PH_AFTERL: begin
        if (c == "l") begin
          lkind_nxt = LK_LL;
          phase_nxt = PH_CONV;
        end else begin
          go_conv = 1'b1;
        end
      end
      PH_CONV: go_conv = 1'b1;
      default: begin
        if ((phase_r != PH_FLAGS) && (c == CH_PERCENT)) begin
          emit  = 1'b1;
          code  = CH_PERCENT;
          taken = 1'b1;
        end else begin
          case (c)
            CH_MINUS: begin
              pad_nxt   = PAD_LEFT;
              phase_nxt = PH_FLAGS;
            end
            CH_PLUS: begin
              sgn_nxt   = SGN_PLUS;
              phase_nxt = PH_FLAGS;
            end
            CH_SPACE: begin
              if (sgn_nxt != SGN_PLUS) sgn_nxt = SGN_SPACE;
              phase_nxt = PH_FLAGS;
            end
            CH_HASH: begin
              alt_nxt   = 1'b1;
              phase_nxt = PH_FLAGS;
            end
            CH_ZERO: begin
              if (pad_nxt != PAD_LEFT) pad_nxt = PAD_ZERO;
              phase_nxt = PH_FLAGS;
            end
            CH_STAR: begin
              if (star[31]) pad_nxt = PAD_LEFT;
              fwidth_nxt = star_mag;
              phase_nxt  = (star_mag > max_field) ? PH_SKIP : PH_AFTERW;
            end
            default: begin
              if (is_dig) begin
                fwidth_nxt = {28'd0, c[3:0]};
                phase_nxt  = PH_WDIG;
              end else begin
                fwidth_nxt = '0;
                go_endw    = 1'b1;
              end
            end
          endcase
        end
      end
    endcase

    if (go_endw) begin
      if (fwidth_nxt > max_field) begin
        go_inval = 1'b1;
      end else begin
        go_afterw = 1'b1;
      end
    end

    if (go_afterw) begin
      if (c == CH_DOT) begin
        pgiven_nxt = 1'b1;
        phase_nxt  = PH_PSTART;
      end else begin
        go_len = 1'b1;
      end
    end

    if (go_len) begin
      case (c)
        "h": begin
          lkind_nxt = LK_H;
          phase_nxt = PH_AFTERH;
        end
        "l": begin
          lkind_nxt = LK_L;
          phase_nxt = PH_AFTERL;
        end
        "j": begin
          lkind_nxt = LK_J;
          phase_nxt = PH_CONV;
        end
        "z": begin
          lkind_nxt = LK_Z;
          phase_nxt = PH_CONV;
        end
        "t": begin
          lkind_nxt = LK_T;
          phase_nxt = PH_CONV;
        end
        "L": begin
          lkind_nxt = LK_BIGL;
          phase_nxt = PH_CONV;
        end
        default: go_conv = 1'b1;
      endcase
    end

    if (go_conv) begin
      emit = 1'b1;
      case (c)
        "d", "i", "o", "u", "x", "X": begin
          if ((lkind_nxt == LK_WIDE) || (lkind_nxt == LK_BIGL)) code = CODE_BAD;
          if (!pgiven_nxt) begin
            prec_nxt = 32'd1;
          end else if (pad_nxt == PAD_ZERO) begin
            pad_nxt = PAD_RIGHT;
          end
        end
        "p": begin
          code      = "x";
          alt_nxt   = 1'b1;
          lkind_nxt = LK_L;
          prec_nxt  = 32'd8;
        end
        "c": begin
          if (lkind_nxt == LK_L) begin
            lkind_nxt = LK_HH;
          end else if (lkind_nxt != LK_NONE) begin
            code = CODE_BAD;
          end
        end
        "s": begin
          if (lkind_nxt == LK_L) begin
            lkind_nxt = LK_WIDE;
          end else if (lkind_nxt != LK_NONE) begin
            code = CODE_BAD;
          end
        end
        "n": begin
          if (lkind_nxt == LK_BIGL) code = CODE_BAD;
        end
        "a", "A": begin
          if (!pgiven_nxt) prec_nxt = 32'd13;
          if ((lkind_nxt != LK_NONE) && (lkind_nxt != LK_BIGL)) code = CODE_BAD;
        end
        "f", "F", "e", "E": begin
          if (!pgiven_nxt) prec_nxt = 32'd6;
          if ((lkind_nxt != LK_NONE) && (lkind_nxt != LK_BIGL)) code = CODE_BAD;
        end
        "g", "G": begin
          if (!pgiven_nxt) begin
            prec_nxt = 32'd6;
          end else if (prec_nxt == 32'd0) begin
            prec_nxt = 32'd1;
          end
          if ((lkind_nxt != LK_NONE) && (lkind_nxt != LK_BIGL)) code = CODE_BAD;
        end
        CH_PERCENT: code = CH_PERCENT;
        default: code = CODE_BAD;
      endcase
    end

    if (go_inval) begin
      emit       = 1'b1;
      code       = CODE_BAD;
      lkind_nxt  = LK_NONE;
      pgiven_nxt = 1'b0;
      prec_nxt   = '0;
    end

    if (emit) begin
      res.padding_mode     = pad_nxt;
      res.sign_mode        = sgn_nxt;
      res.precision_given  = pgiven_nxt;
      res.alternate_form   = alt_nxt;
      res.length_kind      = lkind_nxt;
      res.conversion_code  = code;
      res.field_width      = fwidth_nxt;
      res.precision_value  = prec_nxt;
      res.terminator_taken = taken;
      phase_nxt  = PH_FIRST;
      pad_nxt    = PAD_RIGHT;
      sgn_nxt    = SGN_NONE;
      pgiven_nxt = 1'b0;
      alt_nxt    = 1'b0;
      lkind_nxt  = LK_NONE;
      fwidth_nxt = '0;
      prec_nxt   = '0;
    end
  end

  assign res_valid = fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      pad_r    <= PAD_RIGHT;
      sgn_r    <= SGN_NONE;
      pgiven_r <= 1'b0;
      alt_r    <= 1'b0;
      lkind_r  <= LK_NONE;
      fwidth_r <= '0;
      prec_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pad_r    <= pad_nxt;
      sgn_r    <= sgn_nxt;
      pgiven_r <= pgiven_nxt;
      alt_r    <= alt_nxt;
      lkind_r  <= lkind_nxt;
      fwidth_r <= fwidth_nxt;
      prec_r   <= prec_nxt;
    end
  end

`ifndef SYNTH
  a_emit_returns_first: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (phase_r == PH_FIRST))
    else $error("parser did not return to the first phase after a result");

  a_first_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIRST) |-> ((fwidth_r == 32'd0) && (prec_r == 32'd0) &&
                               (lkind_r == LK_NONE) && !pgiven_r))
    else $error("working fields not cleared at the start of a conversion");

  a_result_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ((res.padding_mode != 2'd3) && (res.sign_mode != 2'd3) &&
                   (res.length_kind <= LK_WIDE)))
    else $error("result field out of range");
`endif

endmodule
